// ----- src/stt_pkg.sv -----
`timescale 1ns / 1ps

package stt_pkg;

    localparam int KEY_W   = 64;
    localparam int SCORE_W = 32;
    localparam int DEPTH_W = 7;
    localparam int KIND_W  = 2;
    localparam int MOVE_W  = 32;
    localparam int CFG_W   = 4;

    localparam logic [CFG_W-1:0] INDEX_BITS_RESET = 4'd12;

    localparam logic CMD_PROBE = 1'b0;
    localparam logic CMD_STORE = 1'b1;

    // exact score, upper bound (failed low), lower bound (failed high)
    localparam logic [KIND_W-1:0] BOUND_EXACT = 2'd0;
    localparam logic [KIND_W-1:0] BOUND_UPPER = 2'd1;
    localparam logic [KIND_W-1:0] BOUND_LOWER = 2'd2;

    typedef struct packed {
        logic                       cutoff_hit;
        logic signed [SCORE_W-1:0]  result_score;
        logic                       key_matched;
        logic [MOVE_W-1:0]          stored_move;
        logic                       written;
    } t_result;

endpackage

// ----- src/search_transposition_table.sv -----
`timescale 1ns / 1ps

// Direct-mapped transposition table with depth-preferred replacement.
// Input channel: one probe or store command per beat (i_in_valid / o_in_stall).
// Output channel: exactly one result beat per command, in order
// (o_out_valid / i_out_stall).
// A command is registered in the lookup stage, its result in the output register.
// Throughput: one command per cycle without a receiver stall or clearing pass.
// The table is a single memory with a registered read; read-modify-write of
// back-to-back commands on one entry is covered by forwarding the last write.
// Reset: index_bits returns to 12 and a clearing pass zeroes every entry, one
// entry per cycle. o_in_stall stays high during the pass; configuration writes
// are taken at any time.
// Receiver stall: the result is held in the output register; one more command
// may sit in the lookup stage, after which o_in_stall rises.
// Configuration: i_cfg_we / i_cfg_data write index_bits; write only when idle.
module search_transposition_table #(
    parameter int INDEX_WIDTH = 12,
    parameter int MOVE_WIDTH  = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [stt_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_cmd,
    input  logic [stt_pkg::KEY_W-1:0]          i_hash_key,
    input  logic signed [stt_pkg::SCORE_W-1:0] i_entry_score,
    input  logic [stt_pkg::DEPTH_W-1:0]        i_search_depth,
    input  logic [stt_pkg::KIND_W-1:0]         i_bound_kind,
    input  logic [stt_pkg::MOVE_W-1:0]         i_move_word,
    input  logic signed [stt_pkg::SCORE_W-1:0] i_alpha_bound,
    input  logic signed [stt_pkg::SCORE_W-1:0] i_beta_bound,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_cutoff_hit,
    output logic signed [stt_pkg::SCORE_W-1:0] o_result_score,
    output logic                               o_key_matched,
    output logic [stt_pkg::MOVE_W-1:0]         o_stored_move,
    output logic                               o_written
);

    localparam int MoveKeep = (MOVE_WIDTH < stt_pkg::MOVE_W) ? MOVE_WIDTH : stt_pkg::MOVE_W;
    localparam int MoveLo   = 0;
    localparam int KindLo   = MoveLo + MoveKeep;
    localparam int DepthLo  = KindLo + stt_pkg::KIND_W;
    localparam int ScoreLo  = DepthLo + stt_pkg::DEPTH_W;
    localparam int KeyLo    = ScoreLo + stt_pkg::SCORE_W;
    localparam int EntryW   = KeyLo + stt_pkg::KEY_W;

    // control
    logic [stt_pkg::CFG_W-1:0] r_index_bits;
    logic                      r_clearing;
    logic [INDEX_WIDTH-1:0]    r_clr_addr;
    logic                      r_s1_valid;
    logic                      r_out_valid;
    logic                      r_wr_valid;

    // lookup stage payload
    logic                               r_s1_cmd;
    logic [stt_pkg::KEY_W-1:0]          r_s1_key;
    logic signed [stt_pkg::SCORE_W-1:0] r_s1_score;
    logic [stt_pkg::DEPTH_W-1:0]        r_s1_depth;
    logic [stt_pkg::KIND_W-1:0]         r_s1_kind;
    logic [MoveKeep-1:0]                r_s1_move;
    logic signed [stt_pkg::SCORE_W-1:0] r_s1_alpha;
    logic signed [stt_pkg::SCORE_W-1:0] r_s1_beta;
    logic [INDEX_WIDTH-1:0]             r_s1_idx;

    // last write, for forwarding
    logic [INDEX_WIDTH-1:0] r_wr_idx;
    logic [EntryW-1:0]      r_wr_data;

    stt_pkg::t_result r_out;

    logic [INDEX_WIDTH-1:0] w_mask;
    logic [INDEX_WIDTH-1:0] w_in_idx;
    logic                   w_accept;
    logic                   w_adv;
    logic [EntryW-1:0]      w_rdata;
    logic [EntryW-1:0]      w_entry;
    logic [EntryW-1:0]      w_new_entry;
    stt_pkg::t_result       w_res;
    logic                   w_mem_we;
    logic [INDEX_WIDTH-1:0] w_mem_waddr;
    logic [EntryW-1:0]      w_mem_wdata;
    logic                   n_clearing;

    // index_bits of 0 acts as 1; values above INDEX_WIDTH fall off the top
    always_comb begin
        for (int i = 0; i < INDEX_WIDTH; i++) begin
            w_mask[i] = (i == 0) || (i < int'(r_index_bits));
        end
    end

    assign w_in_idx   = i_hash_key[INDEX_WIDTH-1:0] & w_mask;
    assign w_adv      = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_clearing || (r_s1_valid && !w_adv);
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_entry = (r_wr_valid && r_wr_idx == r_s1_idx) ? r_wr_data : w_rdata;

    stt_eval #(
        .MOVE_KEEP (MoveKeep)
    ) u_eval (
        .i_cmd       (r_s1_cmd),
        .i_key       (r_s1_key),
        .i_depth     (r_s1_depth),
        .i_alpha     (r_s1_alpha),
        .i_beta      (r_s1_beta),
        .i_ent_key   (w_entry[KeyLo +: stt_pkg::KEY_W]),
        .i_ent_score (w_entry[ScoreLo +: stt_pkg::SCORE_W]),
        .i_ent_depth (w_entry[DepthLo +: stt_pkg::DEPTH_W]),
        .i_ent_kind  (w_entry[KindLo +: stt_pkg::KIND_W]),
        .i_ent_move  (w_entry[MoveLo +: MoveKeep]),
        .o_res       (w_res)
    );

    assign w_new_entry = {r_s1_key, r_s1_score, r_s1_depth, r_s1_kind, r_s1_move};

    always_comb begin
        if (r_clearing) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = r_clr_addr;
            w_mem_wdata = '0;
        end else begin
            w_mem_we    = w_adv && w_res.written;
            w_mem_waddr = r_s1_idx;
            w_mem_wdata = w_new_entry;
        end
    end

    stt_mem #(
        .ADDR_W (INDEX_WIDTH),
        .DATA_W (EntryW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_accept),
        .i_raddr (w_in_idx),
        .o_rdata (w_rdata)
    );

    assign n_clearing = r_clearing && !(&r_clr_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits <= stt_pkg::INDEX_BITS_RESET;
            r_clearing   <= 1'b1;
            r_clr_addr   <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_wr_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_index_bits <= i_cfg_data;
            end
            r_clearing <= n_clearing;
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_adv && w_res.written) begin
                r_wr_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_cmd   <= i_cmd;
            r_s1_key   <= i_hash_key;
            r_s1_score <= i_entry_score;
            r_s1_depth <= i_search_depth;
            r_s1_kind  <= i_bound_kind;
            r_s1_move  <= i_move_word[MoveKeep-1:0];
            r_s1_alpha <= i_alpha_bound;
            r_s1_beta  <= i_beta_bound;
            r_s1_idx   <= w_in_idx;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
        if (w_adv && w_res.written) begin
            r_wr_idx  <= r_s1_idx;
            r_wr_data <= w_new_entry;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_cutoff_hit   = r_out.cutoff_hit;
    assign o_result_score = r_out.result_score;
    assign o_key_matched  = r_out.key_matched;
    assign o_stored_move  = r_out.stored_move;
    assign o_written      = r_out.written;

endmodule

// ----- src/stt_mem.sv -----
`timescale 1ns / 1ps

module stt_mem #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 137
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    // read returns the old contents when the same entry is written in that cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/stt_eval.sv -----
`timescale 1ns / 1ps

module stt_eval #(
    parameter int MOVE_KEEP = 32
) (
    input  logic                               i_cmd,
    input  logic [stt_pkg::KEY_W-1:0]          i_key,
    input  logic [stt_pkg::DEPTH_W-1:0]        i_depth,
    input  logic signed [stt_pkg::SCORE_W-1:0] i_alpha,
    input  logic signed [stt_pkg::SCORE_W-1:0] i_beta,
    input  logic [stt_pkg::KEY_W-1:0]          i_ent_key,
    input  logic signed [stt_pkg::SCORE_W-1:0] i_ent_score,
    input  logic [stt_pkg::DEPTH_W-1:0]        i_ent_depth,
    input  logic [stt_pkg::KIND_W-1:0]         i_ent_kind,
    input  logic [MOVE_KEEP-1:0]               i_ent_move,
    output stt_pkg::t_result                   o_res
);

    logic w_key_eq;

    assign w_key_eq = (i_ent_key == i_key);

    always_comb begin
        o_res = '0;
        if (i_cmd == stt_pkg::CMD_STORE) begin
            o_res.written = (i_ent_depth <= i_depth) || w_key_eq;
        end else if (w_key_eq) begin
            o_res.key_matched = 1'b1;
            o_res.stored_move = stt_pkg::MOVE_W'(i_ent_move);
            if (i_ent_depth >= i_depth) begin
                priority if (i_ent_kind == stt_pkg::BOUND_EXACT) begin
                    o_res.cutoff_hit   = 1'b1;
                    o_res.result_score = i_ent_score;
                end else if (i_ent_kind == stt_pkg::BOUND_LOWER && i_ent_score >= i_beta) begin
                    o_res.cutoff_hit   = 1'b1;
                    o_res.result_score = i_beta;
                end else if (i_ent_kind == stt_pkg::BOUND_UPPER && i_ent_score <= i_alpha) begin
                    o_res.cutoff_hit   = 1'b1;
                    o_res.result_score = i_alpha;
                end else begin
                    o_res.cutoff_hit   = 1'b0;
                end
            end
        end
    end

endmodule
